[rtl/ptc_pkg.sv]
// Shared types, register map and helper functions for the pressure and
// temperature compensation pipeline. No dependencies.
package ptc_pkg;

	localparam int DIV_W    = 32;
	localparam int REG_NUM  = 6;
	localparam int ADDR_W   = 5;

	// register indexes
	localparam logic [2:0] REG_T1_T2 = 3'd0;
	localparam logic [2:0] REG_T3_P1 = 3'd1;
	localparam logic [2:0] REG_P2_P3 = 3'd2;
	localparam logic [2:0] REG_P4_P5 = 3'd3;
	localparam logic [2:0] REG_P6_P7 = 3'd4;
	localparam logic [2:0] REG_P8_P9 = 3'd5;

	localparam logic [31:0] P_OFFSET  = 32'd64000;
	localparam logic [31:0] RAW_FULL  = 32'd1048576;
	localparam logic [31:0] P_SCALE   = 32'd3125;
	localparam logic [31:0] DIV_SPLIT = 32'h8000_0000;
	localparam logic [31:0] ROUND_T   = 32'd128;
	localparam logic [31:0] P1_BIAS   = 32'd32768;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_pa;
		logic               pressure_valid;
	} result_t;

	typedef struct packed {
		logic [31:0] t1_t2;
		logic [31:0] t3_p1;
		logic [31:0] p2_p3;
		logic [31:0] p4_p5;
		logic [31:0] p6_p7;
		logic [31:0] p8_p9;
	} cal_t;

	// sideband carried alongside the divider
	typedef struct packed {
		logic [31:0] temp;
		logic        post_double;
		logic        zero;
	} side_t;

	typedef struct packed {
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
		side_t            side;
	} div_in_t;

	// sign extend a 16-bit word to 32 bits
	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// signed division by 2**sh, truncating toward zero
	function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input int sh);
		logic [31:0] mag;
		logic [31:0] r;
		mag = x[31] ? (~x + 32'd1) : x;
		r   = mag >> sh;
		return x[31] ? (~r + 32'd1) : r;
	endfunction

endpackage

[rtl/ptc_regs.sv]
// Calibration register file behind the APB-style port.
// Depends on ptc_pkg.
module ptc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output ptc_pkg::cal_t              cal
);

	logic [2:0] idx;
	logic       wr;
	ptc_pkg::cal_t cal_q;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cal    = cal_q;

	// register writes, out-of-range indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr) begin
			unique case (idx)
				ptc_pkg::REG_T1_T2: cal_q.t1_t2 <= pwdata;
				ptc_pkg::REG_T3_P1: cal_q.t3_p1 <= pwdata;
				ptc_pkg::REG_P2_P3: cal_q.p2_p3 <= pwdata;
				ptc_pkg::REG_P4_P5: cal_q.p4_p5 <= pwdata;
				ptc_pkg::REG_P6_P7: cal_q.p6_p7 <= pwdata;
				ptc_pkg::REG_P8_P9: cal_q.p8_p9 <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			ptc_pkg::REG_T1_T2: prdata = cal_q.t1_t2;
			ptc_pkg::REG_T3_P1: prdata = cal_q.t3_p1;
			ptc_pkg::REG_P2_P3: prdata = cal_q.p2_p3;
			ptc_pkg::REG_P4_P5: prdata = cal_q.p4_p5;
			ptc_pkg::REG_P6_P7: prdata = cal_q.p6_p7;
			ptc_pkg::REG_P8_P9: prdata = cal_q.p8_p9;
			default:            prdata = '0;
		endcase
	end

endmodule

[rtl/ptc_front.sv]
// Temperature formula and pressure divisor / dividend terms, 13 stages.
// Depends on ptc_pkg.
module ptc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  ptc_pkg::sample_t   din,
	input  ptc_pkg::cal_t      cal,
	output logic               vout,
	output ptc_pkg::div_in_t   dout
);

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
	assign t1 = {16'd0, cal.t1_t2[15:0]};
	assign t2 = ptc_pkg::sx16(cal.t1_t2[31:16]);
	assign t3 = ptc_pkg::sx16(cal.t3_p1[15:0]);
	assign p1 = {16'd0, cal.t3_p1[31:16]};
	assign p2 = ptc_pkg::sx16(cal.p2_p3[15:0]);
	assign p3 = ptc_pkg::sx16(cal.p2_p3[31:16]);
	assign p4 = ptc_pkg::sx16(cal.p4_p5[15:0]);
	assign p5 = ptc_pkg::sx16(cal.p4_p5[31:16]);
	assign p6 = ptc_pkg::sx16(cal.p6_p7[15:0]);

	logic [13:1] v_q;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6;
	logic [19:0] adcp_s7, adcp_s8, adcp_s9, adcp_s10;
	logic [31:0] a_s1, b_s1, pa_s2, bb_s2, v1_s3, sb_s3, v1_s4, m_s4, tf_s5;
	logic [31:0] temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11, temp_s12;
	logic [31:0] pv1_s6, q_s6, qq_s7, p5m_s7, p2m_s7;
	logic [31:0] a1_s8, p5x2_s8, c_s8, d_s8, m6_s9, m3_s9, p5x2_s9, d_s9;
	logic [31:0] v2_s10, e_s10, f_s11, g_s11, den_s12, pp_s12;
	ptc_pkg::div_in_t d_s13;

	logic [31:0] v2_sum, tf5;
	assign v2_sum = m6_s9 + p5x2_s9;
	assign tf5    = (tf_s5 << 2) + tf_s5 + ptc_pkg::ROUND_T;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[12:1], vin};
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: offsets of raw temperature
			a_s1    <= {15'd0, din.raw_temperature[19:3]} - (t1 << 1);
			b_s1    <= {16'd0, din.raw_temperature[19:4]} - t1;
			adcp_s1 <= din.raw_pressure;
			// s2: products
			pa_s2   <= a_s1 * t2;
			bb_s2   <= b_s1 * b_s1;
			adcp_s2 <= adcp_s1;
			// s3
			v1_s3   <= ptc_pkg::sdiv_p2(pa_s2, 11);
			sb_s3   <= ptc_pkg::sdiv_p2(bb_s2, 12);
			adcp_s3 <= adcp_s2;
			// s4
			v1_s4   <= v1_s3;
			m_s4    <= sb_s3 * t3;
			adcp_s4 <= adcp_s3;
			// s5: fine temperature
			tf_s5   <= v1_s4 + ptc_pkg::sdiv_p2(m_s4, 14);
			adcp_s5 <= adcp_s4;
			// s6: temperature out, pressure offset
			temp_s6 <= ptc_pkg::sdiv_p2(tf5, 8);
			pv1_s6  <= ptc_pkg::sdiv_p2(tf_s5, 1) - ptc_pkg::P_OFFSET;
			q_s6    <= ptc_pkg::sdiv_p2(ptc_pkg::sdiv_p2(tf_s5, 1) - ptc_pkg::P_OFFSET, 2);
			adcp_s6 <= adcp_s5;
			// s7
			qq_s7   <= q_s6 * q_s6;
			p5m_s7  <= pv1_s6 * p5;
			p2m_s7  <= p2 * pv1_s6;
			temp_s7 <= temp_s6;
			adcp_s7 <= adcp_s6;
			// s8
			a1_s8   <= ptc_pkg::sdiv_p2(qq_s7, 11);
			p5x2_s8 <= p5m_s7 << 1;
			c_s8    <= ptc_pkg::sdiv_p2(qq_s7, 13);
			d_s8    <= ptc_pkg::sdiv_p2(p2m_s7, 1);
			temp_s8 <= temp_s7;
			adcp_s8 <= adcp_s7;
			// s9
			m6_s9   <= a1_s8 * p6;
			m3_s9   <= p3 * c_s8;
			p5x2_s9 <= p5x2_s8;
			d_s9    <= d_s8;
			temp_s9 <= temp_s8;
			adcp_s9 <= adcp_s8;
			// s10
			v2_s10   <= ptc_pkg::sdiv_p2(v2_sum, 2) + (p4 << 16);
			e_s10    <= ptc_pkg::sdiv_p2(ptc_pkg::sdiv_p2(m3_s9, 3) + d_s9, 18);
			temp_s10 <= temp_s9;
			adcp_s10 <= adcp_s9;
			// s11
			f_s11    <= (ptc_pkg::P1_BIAS + e_s10) * p1;
			g_s11    <= (ptc_pkg::RAW_FULL - {12'd0, adcp_s10}) - ptc_pkg::sdiv_p2(v2_s10, 12);
			temp_s11 <= temp_s10;
			// s12
			den_s12  <= ptc_pkg::sdiv_p2(f_s11, 15);
			pp_s12   <= g_s11 * ptc_pkg::P_SCALE;
			temp_s12 <= temp_s11;
			// s13: pick double-before or double-after
			d_s13.den              <= den_s12;
			d_s13.side.temp        <= temp_s12;
			d_s13.side.zero        <= (den_s12 == '0);
			if (pp_s12 < ptc_pkg::DIV_SPLIT) begin
				d_s13.num              <= pp_s12 << 1;
				d_s13.side.post_double <= 1'b0;
			end else begin
				d_s13.num              <= pp_s12;
				d_s13.side.post_double <= 1'b1;
			end
		end
	end

	assign vout = v_q[13];
	assign dout = d_s13;

endmodule

[rtl/ptc_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on ptc_pkg.
module ptc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vin,
	input  ptc_pkg::div_in_t          din,
	output logic                      vout,
	output logic [ptc_pkg::DIV_W-1:0] quo,
	output ptc_pkg::side_t            side
);

	localparam int W = ptc_pkg::DIV_W;

	logic [W-1:0]   num_s [W+1];
	logic [W-1:0]   den_s [W+1];
	logic [W-1:0]   rem_s [W+1];
	logic [W-1:0]   quo_s [W+1];
	ptc_pkg::side_t sd_s  [W+1];
	logic [W:0]     v_q;

	assign num_s[0] = din.num;
	assign den_s[0] = din.den;
	assign rem_s[0] = '0;
	assign quo_s[0] = '0;
	assign sd_s[0]  = din.side;
	assign v_q[0]   = vin;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[W:1] <= '0;
		end else if (en) begin
			v_q[W:1] <= v_q[W-1:0];
		end
	end

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		assign trial = {rem_s[i], num_s[i][W-1]};
		assign diff  = trial - {1'b0, den_s[i]};

		// one restoring step
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1] <= num_s[i] << 1;
				den_s[i+1] <= den_s[i];
				sd_s[i+1]  <= sd_s[i];
				if (!diff[W]) begin
					rem_s[i+1] <= diff[W-1:0];
					quo_s[i+1] <= {quo_s[i][W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= trial[W-1:0];
					quo_s[i+1] <= {quo_s[i][W-2:0], 1'b0};
				end
			end
		end
	end

	assign vout = v_q[W];
	assign quo  = quo_s[W];
	assign side = sd_s[W];

endmodule

[rtl/ptc_back.sv]
// Pressure correction after the divide, five stages ending in the output beat.
// Depends on ptc_pkg.
module ptc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  logic [31:0]       quo,
	input  ptc_pkg::side_t    side,
	input  ptc_pkg::cal_t     cal,
	output logic              vout,
	output ptc_pkg::result_t  dout
);

	logic [31:0] p7, p8, p9;
	assign p7 = ptc_pkg::sx16(cal.p6_p7[31:16]);
	assign p8 = ptc_pkg::sx16(cal.p8_p9[15:0]);
	assign p9 = ptc_pkg::sx16(cal.p8_p9[31:16]);

	logic [5:1]  v_q;
	logic [31:0] p_s1, p_s2, p_s3, p_s4;
	logic [31:0] sq_s2, pd4_s2, m9_s3, m8_s3, sum_s4;
	logic [31:0] temp_s1, temp_s2, temp_s3, temp_s4;
	logic        zero_s1, zero_s2, zero_s3, zero_s4;
	logic [31:0] p8th, sqfull, corr;
	ptc_pkg::result_t r_s5;

	assign p8th   = p_s1 >> 3;
	assign sqfull = p8th * p8th;
	assign corr   = ptc_pkg::sdiv_p2(sum_s4 + p7, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:1], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: undo the split doubling
			p_s1    <= side.post_double ? (quo << 1) : quo;
			temp_s1 <= side.temp;
			zero_s1 <= side.zero;
			// s2
			sq_s2   <= sqfull >> 13;
			pd4_s2  <= p_s1 >> 2;
			p_s2    <= p_s1;
			temp_s2 <= temp_s1;
			zero_s2 <= zero_s1;
			// s3
			m9_s3   <= p9 * sq_s2;
			m8_s3   <= pd4_s2 * p8;
			p_s3    <= p_s2;
			temp_s3 <= temp_s2;
			zero_s3 <= zero_s2;
			// s4
			sum_s4  <= ptc_pkg::sdiv_p2(m9_s3, 12) + ptc_pkg::sdiv_p2(m8_s3, 13);
			p_s4    <= p_s3;
			temp_s4 <= temp_s3;
			zero_s4 <= zero_s3;
			// s5: output beat, zero divisor forces invalid
			r_s5.temperature_centi <= temp_s4;
			r_s5.pressure_valid    <= !zero_s4;
			r_s5.pressure_pa       <= zero_s4 ? '0 : (p_s4 + corr);
		end
	end

	assign vout = v_q[5];
	assign dout = r_s5;

endmodule

[rtl/pressure_temperature_compensation.sv]
// Top level: calibration registers, front formulas, divider, back correction.
// Depends on ptc_pkg, ptc_regs, ptc_front, ptc_div, ptc_back.
//
//  channel  | direction | handshake                    | beat
//  sample   | in        | sample_valid / sample_stall  | ptc_pkg::sample_t
//  result   | out       | result_valid / result_stall  | ptc_pkg::result_t
//  config   | in        | psel/penable/pwrite/pready   | 32-bit register
//
// One beat per cycle while no result is stalled; 13 front stages, 32 divider
// stages of one quotient bit each, 5 back stages.
// Reset clears calibration registers and all valid bits.
// A stalled result freezes the whole pipeline; sample_stall follows it.
module pressure_temperature_compensation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  ptc_pkg::sample_t           sample,
	output logic                       result_valid,
	input  logic                       result_stall,
	output ptc_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ptc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	ptc_pkg::cal_t    cal;
	ptc_pkg::div_in_t div_in;
	ptc_pkg::side_t   div_side;
	logic [31:0]      div_quo;
	logic             en, fv, dv;

	// global advance: hold everything while the output beat waits
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	ptc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cal
	);

	ptc_front u_front (
		.clk, .arst_n, .en, .vin(sample_valid), .din(sample), .cal,
		.vout(fv), .dout(div_in)
	);

	ptc_div u_div (
		.clk, .arst_n, .en, .vin(fv), .din(div_in),
		.vout(dv), .quo(div_quo), .side(div_side)
	);

	ptc_back u_back (
		.clk, .arst_n, .en, .vin(dv), .quo(div_quo), .side(div_side), .cal,
		.vout(result_valid), .dout(result)
	);

	// invalid pressure always reads zero
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.pressure_valid |-> result.pressure_pa == '0)
		else $error("invalid pressure not zero");

	// input is only held off by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("input stalled without output back-pressure");

	// a write to the first register lands
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[4:2] == ptc_pkg::REG_T1_T2
		|=> cal.t1_t2 == $past(pwdata))
		else $error("calibration write lost");

endmodule

[dv/pressure_temperature_compensation_tb.sv]
// Testbench for the pressure/temperature compensation pipeline: random and
// directed raw sample pairs under several calibration sets, checked against
// an in-bench integer model. Depends on ptc_pkg and the RTL top level.
`timescale 1ns / 100ps

module pressure_temperature_compensation_tb;

	localparam int PIPE_LAT = 50;

	logic                      clk;
	logic                      arst_n;
	logic                      sample_valid;
	logic                      sample_stall;
	ptc_pkg::sample_t          sample;
	logic                      result_valid;
	logic                      result_stall;
	ptc_pkg::result_t          result;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [ptc_pkg::ADDR_W-1:0] paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;

	pressure_temperature_compensation DUT (.*);

	// calibration shadow and queues
	logic [31:0]      cal_shadow [ptc_pkg::REG_NUM];
	ptc_pkg::sample_t pending_samples[$];
	ptc_pkg::result_t expected_results[$];
	int               mismatch_count;
	int               gap_left;
	int               rstall_left;
	bit               hold_sender;

	// clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// signed division by a positive constant, truncating toward zero
	function automatic logic [31:0] div_trunc(input logic [31:0] x, input logic [31:0] d);
		logic [31:0] m;
		if (x[31]) begin
			m = ~x + 32'd1;
			return 32'd0 - (m / d);
		end
		return x / d;
	endfunction

	function automatic logic [31:0] sext(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// compensation formulas on the shadow calibration
	function automatic ptc_pkg::result_t compensate(input ptc_pkg::sample_t s);
		ptc_pkg::result_t r;
		logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] a, b, v1, v2, q, t_fine, p, sq;
		adc_t = {12'd0, s.raw_temperature};
		adc_p = {12'd0, s.raw_pressure};
		t1 = {16'd0, cal_shadow[ptc_pkg::REG_T1_T2][15:0]};
		t2 = sext(cal_shadow[ptc_pkg::REG_T1_T2][31:16]);
		t3 = sext(cal_shadow[ptc_pkg::REG_T3_P1][15:0]);
		p1 = {16'd0, cal_shadow[ptc_pkg::REG_T3_P1][31:16]};
		p2 = sext(cal_shadow[ptc_pkg::REG_P2_P3][15:0]);
		p3 = sext(cal_shadow[ptc_pkg::REG_P2_P3][31:16]);
		p4 = sext(cal_shadow[ptc_pkg::REG_P4_P5][15:0]);
		p5 = sext(cal_shadow[ptc_pkg::REG_P4_P5][31:16]);
		p6 = sext(cal_shadow[ptc_pkg::REG_P6_P7][15:0]);
		p7 = sext(cal_shadow[ptc_pkg::REG_P6_P7][31:16]);
		p8 = sext(cal_shadow[ptc_pkg::REG_P8_P9][15:0]);
		p9 = sext(cal_shadow[ptc_pkg::REG_P8_P9][31:16]);
		// temperature
		a = div_trunc(adc_t, 8) - t1 * 32'd2;
		v1 = div_trunc(a * t2, 2048);
		b = div_trunc(adc_t, 16) - t1;
		v2 = div_trunc(div_trunc(b * b, 4096) * t3, 16384);
		t_fine = v1 + v2;
		r.temperature_centi = div_trunc(t_fine * 32'd5 + 32'd128, 256);
		// pressure divisor
		v1 = div_trunc(t_fine, 2) - 32'd64000;
		q = div_trunc(v1, 4);
		v2 = div_trunc(q * q, 2048) * p6;
		v2 = v2 + v1 * p5 * 32'd2;
		v2 = div_trunc(v2, 4) + p4 * 32'd65536;
		v1 = div_trunc(div_trunc(p3 * div_trunc(q * q, 8192), 8)
			+ div_trunc(p2 * v1, 2), 262144);
		v1 = div_trunc((32'd32768 + v1) * p1, 32768);
		if (v1 == 32'd0) begin
			r.pressure_pa = '0;
			r.pressure_valid = 1'b0;
			return r;
		end
		p = ((32'd1048576 - adc_p) - div_trunc(v2, 4096)) * 32'd3125;
		if (p < 32'h8000_0000)
			p = (p * 32'd2) / v1;
		else
			p = (p / v1) * 32'd2;
		sq = ((p / 8) * (p / 8)) / 8192;
		v1 = div_trunc(p9 * sq, 4096);
		v2 = div_trunc((p / 4) * p8, 8192);
		r.pressure_pa = p + div_trunc(v1 + v2 + p7, 16);
		r.pressure_valid = 1'b1;
		return r;
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			gap_left <= 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				expected_results.push_back(compensate(sample));
				void'(pending_samples.pop_front());
			end
			if (sample_valid && sample_stall) begin
				// hold beat
			end else if (sample_valid && !sample_stall && gap_left == 0 &&
				pending_samples.size() > 0 && !hold_sender) begin
				sample <= pending_samples[0];
				gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
			end else if (sample_valid) begin
				sample_valid <= 1'b0;
				gap_left <= (gap_left == 0) ? 0 : gap_left - 1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_samples.size() > 0 && !hold_sender) begin
				sample_valid <= 1'b1;
				sample <= pending_samples[0];
				gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
			end
		end
	end

	// result monitor with random stall
	always @(posedge clk or negedge arst_n) begin
		ptc_pkg::result_t exp_r;
		if (!arst_n) begin
			result_stall <= 1'b0;
			rstall_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("unexpected result beat %h", result);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.temperature_centi !== result.temperature_centi ||
						exp_r.pressure_pa !== result.pressure_pa ||
						exp_r.pressure_valid !== result.pressure_valid) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display("result mismatch: exp t=%0d p=%0d v=%b got t=%0d p=%0d v=%b",
								exp_r.temperature_centi, exp_r.pressure_pa,
								exp_r.pressure_valid, result.temperature_centi,
								result.pressure_pa, result.pressure_valid);
					end
				end
			end
			if (rstall_left > 0) begin
				rstall_left <= rstall_left - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if ($urandom_range(0, 7) == 0)
					rstall_left <= $urandom_range(0, 19);
			end
		end
	end

	// APB register write: setup then access
	task automatic write_cal(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ptc_pkg::ADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cal_shadow[idx] = val;
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	function automatic ptc_pkg::sample_t rand_sample();
		ptc_pkg::sample_t s;
		s.raw_temperature = $urandom_range(0, 3) == 0 ? 20'($urandom)
			: 20'($urandom_range(400000, 600000));
		s.raw_pressure = $urandom_range(0, 3) == 0 ? 20'($urandom)
			: 20'($urandom_range(250000, 450000));
		return s;
	endfunction

	task automatic load_cal(input int mode);
		logic [31:0] typ [ptc_pkg::REG_NUM];
		// typical sensor trim values
		typ[ptc_pkg::REG_T1_T2] = {16'h6A03, 16'd27504};
		typ[ptc_pkg::REG_T3_P1] = {16'd36477, 16'hFC18};
		typ[ptc_pkg::REG_P2_P3] = {16'h0BD0, 16'hD4BC};
		typ[ptc_pkg::REG_P4_P5] = {16'hFF22, 16'h1AE7};
		typ[ptc_pkg::REG_P6_P7] = {16'h3C22, 16'hFFF9};
		typ[ptc_pkg::REG_P8_P9] = {16'h1770, 16'hC5F0};
		for (int i = 0; i < ptc_pkg::REG_NUM; i++) begin
			case (mode)
				0: write_cal(3'(i), typ[i]);
				1: write_cal(3'(i), 32'hFFFF_FFFF);
				2: write_cal(3'(i), 32'h8000_8000);
				3: write_cal(3'(i), 32'h7FFF_7FFF);
				default: write_cal(3'(i), $urandom_range(0, 1) ? $urandom : typ[i] ^ (32'h0001_0001 << $urandom_range(0, 14)));
			endcase
		end
	endtask

	initial begin
		ptc_pkg::sample_t s;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mismatch_count = 0;
		hold_sender = 1'b0;
		for (int i = 0; i < ptc_pkg::REG_NUM; i++) cal_shadow[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// zero calibration: divisor zero
		s = '{20'd0, 20'd0}; pending_samples.push_back(s);
		s = '{20'hFFFFF, 20'hFFFFF}; pending_samples.push_back(s);
		drain();
		// extremes of fields under typical and extreme calibration sets
		for (int m = 0; m < 4; m++) begin
			load_cal(m);
			pending_samples.push_back('{20'd0, 20'd0});
			pending_samples.push_back('{20'hFFFFF, 20'd0});
			pending_samples.push_back('{20'd0, 20'hFFFFF});
			pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
			pending_samples.push_back('{20'd519888, 20'd415148});
			drain();
		end
		// random calibration phases, every third with the typical set
		for (int ph = 0; ph < 9; ph++) begin
			load_cal(ph % 3 == 0 ? 0 : 4);
			for (int i = 0; i < 150; i++) pending_samples.push_back(rand_sample());
			if (ph == 4) begin
				// let beats build up, then hold the sender until the pipeline is empty
				repeat (200) @(posedge clk);
				hold_sender = 1'b1;
				while (expected_results.size() > 0 || sample_valid) @(posedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end
		if (mismatch_count == 0)
			$display("pressure_temperature_compensation: match");
		else
			$display("pressure_temperature_compensation: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("pressure_temperature_compensation: mismatch");
		$finish;
	end

endmodule
